// ===== rtl/ats_pkg.sv =====
`default_nettype none

package ats_pkg;

    localparam int MAX_STEPS = 24;
    localparam int IDX_W     = 5;
    localparam int VEC_W     = 35;
    localparam int ANG_W     = 26;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = 53;

    typedef logic signed [VEC_W-1:0]   t_vec;
    typedef logic signed [ANG_W-1:0]   t_angle;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_cordic_ctl;

    localparam t_angle      DEG180     = 26'sd11796480;
    localparam logic [15:0] GAIN_RESET = 16'd6554;
    localparam t_mul_b      INV_GAIN   = 18'sd39797;

    // Arctangent of 2^-i in degrees, Q.16.
    function automatic t_angle atan_angle(input logic [IDX_W-1:0] idx);
        case (idx)
            5'd0:    atan_angle = 26'sd2949120;
            5'd1:    atan_angle = 26'sd1740967;
            5'd2:    atan_angle = 26'sd919879;
            5'd3:    atan_angle = 26'sd466945;
            5'd4:    atan_angle = 26'sd234379;
            5'd5:    atan_angle = 26'sd117304;
            5'd6:    atan_angle = 26'sd58666;
            5'd7:    atan_angle = 26'sd29335;
            5'd8:    atan_angle = 26'sd14668;
            5'd9:    atan_angle = 26'sd7334;
            5'd10:   atan_angle = 26'sd3667;
            5'd11:   atan_angle = 26'sd1833;
            5'd12:   atan_angle = 26'sd917;
            5'd13:   atan_angle = 26'sd458;
            5'd14:   atan_angle = 26'sd229;
            5'd15:   atan_angle = 26'sd115;
            5'd16:   atan_angle = 26'sd57;
            5'd17:   atan_angle = 26'sd29;
            5'd18:   atan_angle = 26'sd14;
            5'd19:   atan_angle = 26'sd7;
            5'd20:   atan_angle = 26'sd4;
            5'd21:   atan_angle = 26'sd2;
            5'd22:   atan_angle = 26'sd1;
            default: atan_angle = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ats_in_if.sv =====
`default_nettype none

interface ats_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ats_out_if.sv =====
`default_nettype none

interface ats_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] roll_centideg;
    logic signed [15:0] pitch_centideg;

    modport source (output valid, output roll_centideg, output pitch_centideg,
                    input ready);
    modport sink   (input valid, input roll_centideg, input pitch_centideg,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ats_cfg_if.sv =====
`default_nettype none

interface ats_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] smoothing_gain;

    modport source (output valid, output smoothing_gain, input ready);
    modport sink   (input valid, input smoothing_gain, output ready);
endinterface

`default_nettype wire

// ===== rtl/ats_mul.sv =====
`default_nettype none

module ats_mul (
    input  logic           i_clk,
    input  ats_pkg::t_vec   i_a,
    input  ats_pkg::t_mul_b i_b,
    output ats_pkg::t_prod  o_p
);
    import ats_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/ats_cordic.sv =====
`default_nettype none

module ats_cordic (
    input  logic                i_clk,
    input  ats_pkg::t_cordic_ctl i_ctl,
    input  ats_pkg::t_vec        i_x0,
    input  ats_pkg::t_vec        i_y0,
    input  ats_pkg::t_angle      i_z0,
    output ats_pkg::t_vec        o_x,
    output ats_pkg::t_angle      o_z
);
    import ats_pkg::*;

    t_vec   r_x;
    t_vec   r_y;
    t_angle r_z;
    t_vec   n_x;
    t_vec   n_y;
    t_angle n_z;
    t_vec   dx;
    t_vec   dy;
    t_angle da;

    always_comb begin
        dx  = r_y >>> i_ctl.idx;
        dy  = r_x >>> i_ctl.idx;
        da  = atan_angle(i_ctl.idx);
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_ctl.load) begin
            n_x = i_x0;
            n_y = i_y0;
            n_z = i_z0;
        end else if (i_ctl.step) begin
            if (!r_y[VEC_W-1]) begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + da;
            end else begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - da;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_z = r_z;

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_smoother.sv =====
// Channel   Role   Payload                                  Transfer when
// i_in      sink   accel_x, accel_y, accel_z (s16 each)     valid && ready
// o_out     source roll_centideg (s15), pitch_centideg (s16) valid && ready
// i_cfg     sink   smoothing_gain (u16)                     valid && ready
//
// A sample transfer starts a filter update of each of the three axes through the shared
// multiplier, then three vectoring passes of the one CORDIC stage; the next sample is
// accepted only once the result has gone to the output register.
// The configuration channel is always ready.
// Reset is synchronous and clears the filter state and sets the gain to 6554.
// A stalled result waits in the output register; the next sample is taken
// meanwhile and its result waits for that register to empty.
`default_nettype none

module accel_tilt_smoother #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ats_in_if.sink    i_in,
    ats_out_if.source o_out,
    ats_cfg_if.sink   i_cfg
);
    import ats_pkg::*;

    localparam int EFF_STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(EFF_STEPS - 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EMA_MUL  = 4'd1;
    localparam logic [3:0] ST_EMA_ACC  = 4'd2;
    localparam logic [3:0] ST_R1_LOAD  = 4'd3;
    localparam logic [3:0] ST_R1       = 4'd4;
    localparam logic [3:0] ST_MAG_MUL  = 4'd5;
    localparam logic [3:0] ST_MAG_ACC  = 4'd6;
    localparam logic [3:0] ST_R2       = 4'd7;
    localparam logic [3:0] ST_ROLL_OUT = 4'd8;
    localparam logic [3:0] ST_PITCH    = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam t_prod SAT_HI  = t_prod'(64'sd2147483647);
    localparam t_prod SAT_LO  = t_prod'(-64'sd2147483648);
    localparam t_prod ROUND16 = t_prod'(64'sd32768);
    localparam logic signed [17:0] ROLL_LIM  = 18'sd9000;
    localparam logic signed [17:0] PITCH_LIM = 18'sd18000;

    function automatic logic signed [17:0] to_centideg(input t_angle z,
                                                       input logic signed [17:0] lim);
        logic signed [33:0] w;
        logic signed [17:0] c;
        w = (34'(z) <<< 6) + (34'(z) <<< 5) + (34'(z) <<< 2) + 34'sd32768;
        c = 18'(w >>> 16);
        if (c > lim) begin
            c = lim;
        end else if (c < -lim) begin
            c = -lim;
        end
        return c;
    endfunction

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [IDX_W-1:0]   r_step;
    logic [IDX_W-1:0]   n_step;
    logic [1:0]         r_axis;
    logic [1:0]         n_axis;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [15:0]        r_gain;
    logic signed [31:0] r_smooth [3];
    logic signed [16:0] r_tgt [3];
    logic signed [14:0] r_roll;
    logic signed [14:0] r_out_roll;
    logic signed [15:0] r_out_pitch;

    logic               in_xfer;
    logic               out_load;
    logic signed [33:0] ema_d;
    t_prod              ema_acc;
    t_prod              ema_sh;
    logic signed [31:0] ema_new;
    t_prod              mag_acc;
    t_vec               mag;
    t_vec               mul_a;
    t_mul_b             mul_b;
    t_prod              prod;
    t_vec               f_ext;
    t_vec               s_ext;
    t_vec               t_ext;
    t_vec               abs_f;
    t_vec               abs_t;
    t_cordic_ctl        cor_ctl;
    t_vec               cor_x0;
    t_vec               cor_y0;
    t_angle             cor_z0;
    t_vec               cor_x;
    t_angle             cor_z;
    logic               all_zero;
    logic               ft_zero;
    logic signed [17:0] roll_c;
    logic signed [17:0] pitch_c;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // Filter: new = s + (target*2^16 - s) * alpha / 2^16, rounded and saturated.
    assign ema_d   = 34'($signed({r_tgt[r_axis], 16'b0})) - 34'(r_smooth[r_axis]);
    assign ema_acc = t_prod'($signed({r_smooth[r_axis], 16'b0})) + prod + ROUND16;
    assign ema_sh  = ema_acc >>> 16;

    always_comb begin
        if (ema_sh > SAT_HI) begin
            ema_new = 32'sh7FFFFFFF;
        end else if (ema_sh < SAT_LO) begin
            ema_new = 32'sh80000000;
        end else begin
            ema_new = 32'(ema_sh);
        end
    end

    assign mag_acc = prod + ROUND16;
    assign mag     = VEC_W'(mag_acc >>> 16);

    assign mul_a = (r_state == ST_EMA_MUL) ? VEC_W'(ema_d) : cor_x;
    assign mul_b = (r_state == ST_EMA_MUL) ? $signed({2'b00, r_gain}) : INV_GAIN;

    ats_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign f_ext = VEC_W'(r_smooth[0]);
    assign s_ext = VEC_W'(r_smooth[1]);
    assign t_ext = VEC_W'(r_smooth[2]);
    assign abs_f = f_ext[VEC_W-1] ? -f_ext : f_ext;
    assign abs_t = t_ext[VEC_W-1] ? -t_ext : t_ext;

    always_comb begin
        cor_ctl.load = r_state inside {ST_R1_LOAD, ST_MAG_ACC, ST_ROLL_OUT};
        cor_ctl.step = r_state inside {ST_R1, ST_R2, ST_PITCH};
        cor_ctl.idx  = r_step;
        case (r_state)
            ST_R1_LOAD: begin
                cor_x0 = abs_t;
                cor_y0 = abs_f;
                cor_z0 = '0;
            end
            ST_MAG_ACC: begin
                cor_x0 = mag;
                cor_y0 = s_ext;
                cor_z0 = '0;
            end
            default: begin
                // Pitch with a negative third axis starts from the vector turned by 180 degrees.
                if (t_ext[VEC_W-1]) begin
                    cor_x0 = -t_ext;
                    cor_y0 = -f_ext;
                    cor_z0 = f_ext[VEC_W-1] ? -DEG180 : DEG180;
                end else begin
                    cor_x0 = t_ext;
                    cor_y0 = f_ext;
                    cor_z0 = '0;
                end
            end
        endcase
    end

    ats_cordic u_cordic (
        .i_clk (i_clk),
        .i_ctl (cor_ctl),
        .i_x0  (cor_x0),
        .i_y0  (cor_y0),
        .i_z0  (cor_z0),
        .o_x   (cor_x),
        .o_z   (cor_z)
    );

    assign all_zero = (r_smooth[0] == '0) && (r_smooth[1] == '0) && (r_smooth[2] == '0);
    assign ft_zero  = (r_smooth[0] == '0) && (r_smooth[2] == '0);
    assign roll_c   = all_zero ? '0 : to_centideg(cor_z, ROLL_LIM);
    assign pitch_c  = ft_zero ? '0 : to_centideg(cor_z, PITCH_LIM);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_out_valid = out_load || (r_out_valid && !o_out.ready);
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_axis  = '0;
                    n_state = ST_EMA_MUL;
                end
            end
            ST_EMA_MUL: begin
                n_state = ST_EMA_ACC;
            end
            ST_EMA_ACC: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = ST_R1_LOAD;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_EMA_MUL;
                end
            end
            ST_R1_LOAD: begin
                n_step  = '0;
                n_state = ST_R1;
            end
            ST_R1, ST_R2, ST_PITCH: begin
                if (r_step == LAST_STEP) begin
                    n_step = '0;
                    case (r_state)
                        ST_R1:   n_state = ST_MAG_MUL;
                        ST_R2:   n_state = ST_ROLL_OUT;
                        default: n_state = ST_DONE;
                    endcase
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MAG_MUL: begin
                n_state = ST_MAG_ACC;
            end
            ST_MAG_ACC: begin
                n_state = ST_R2;
            end
            ST_ROLL_OUT: begin
                n_state = ST_PITCH;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= GAIN_RESET;
            r_smooth[0] <= '0;
            r_smooth[1] <= '0;
            r_smooth[2] <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_gain <= i_cfg.smoothing_gain;
            end
            if (r_state == ST_EMA_ACC) begin
                r_smooth[r_axis] <= ema_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tgt[0] <= 17'(i_in.accel_y);
            r_tgt[1] <= -17'(i_in.accel_x);
            r_tgt[2] <= 17'(i_in.accel_z);
        end
        if (r_state == ST_ROLL_OUT) begin
            r_roll <= roll_c[14:0];
        end
        if (out_load) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= pitch_c[15:0];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.roll_centideg  = r_out_roll;
    assign o_out.pitch_centideg = r_out_pitch;

endmodule

`default_nettype wire

// ===== rtl/ats_checker.sv =====
`default_nettype none

module ats_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [14:0] i_roll,
    input logic signed [15:0] i_pitch
);

    // A sample transfer starts the work, so the block is busy in the next cycle.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a sample transfer");

    // A new result is only written while the block is busy.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (!$past(i_out_valid) || $past(i_out_ready))) |-> !$past(i_in_ready))
        else $error("result appeared without a sample in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_roll) && $stable(i_pitch)))
        else $error("stalled result changed");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_roll >= -15'sd9000 && i_roll <= 15'sd9000 &&
                         i_pitch >= -16'sd18000 && i_pitch <= 16'sd18000))
        else $error("angle out of range");

endmodule

bind accel_tilt_smoother ats_checker u_ats_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll      (o_out.roll_centideg),
    .i_pitch     (o_out.pitch_centideg)
);

`default_nettype wire
